// ----- rtl/mts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Types, codes and constant tables of the Morse text sender.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int QUEUE_DEPTH  = 512;
  localparam int REPEAT_DEPTH = 128;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int RPTR_W       = $clog2(REPEAT_DEPTH);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_ENQUEUE = 3'd1,
    FUNC_REPEAT  = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_STOP    = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_MARK       = 3'd1,
    PH_ELEM_GAP   = 3'd2,
    PH_LETTER_GAP = 3'd3,
    PH_WORD_GAP   = 3'd4
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WPM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP = 2'd1;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic       repeat_first;
    logic       paddle;
  } item_t;

  typedef struct packed {
    logic key_down;
    logic sending;
    logic repeating;
    logic dropped;
    logic aborted;
    logic queue_empty;
  } result_t;

  // length in bits 9..7, elements in 6..0, first element in bit 0, 1 = dah
  localparam logic [9:0] CW_TABLE [64] = '{
    10'd0, {3'd6,7'd53}, {3'd6,7'd18}, 10'd0, {3'd7,7'd72}, 10'd0, {3'd5,7'd2},
    {3'd6,7'd30},
    {3'd5,7'd13}, {3'd6,7'd45}, 10'd0, {3'd5,7'd10}, {3'd6,7'd51}, {3'd6,7'd33},
    {3'd6,7'd42}, {3'd5,7'd9},
    {3'd5,7'd31}, {3'd5,7'd30}, {3'd5,7'd28}, {3'd5,7'd24}, {3'd5,7'd16},
    {3'd5,7'd0}, {3'd5,7'd1}, {3'd5,7'd3},
    {3'd5,7'd7}, {3'd5,7'd15}, {3'd6,7'd7}, {3'd6,7'd21}, 10'd0, {3'd5,7'd17},
    10'd0, {3'd6,7'd12},
    {3'd6,7'd22}, {3'd2,7'd2}, {3'd4,7'd1}, {3'd4,7'd5}, {3'd3,7'd1}, {3'd1,7'd0},
    {3'd4,7'd4}, {3'd3,7'd3},
    {3'd4,7'd0}, {3'd2,7'd0}, {3'd4,7'd14}, {3'd3,7'd5}, {3'd4,7'd2}, {3'd2,7'd3},
    {3'd2,7'd1}, {3'd3,7'd7},
    {3'd4,7'd6}, {3'd4,7'd11}, {3'd3,7'd2}, {3'd3,7'd0}, {3'd1,7'd1}, {3'd3,7'd4},
    {3'd4,7'd8}, {3'd3,7'd6},
    {3'd4,7'd9}, {3'd4,7'd13}, {3'd4,7'd3}, 10'd0, 10'd0, 10'd0, 10'd0,
    {3'd6,7'd44}
  };

  // dit length in ms for a speed in wpm, clamped to 5..60
  localparam logic [7:0] DIT_TABLE [64] = '{
    8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd200, 8'd171,
    8'd150, 8'd133, 8'd120, 8'd109, 8'd100, 8'd92,  8'd85,  8'd80,
    8'd75,  8'd70,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,  8'd52,
    8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd40,  8'd38,
    8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,
    8'd30,  8'd29,  8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd25,
    8'd25,  8'd24,  8'd24,  8'd23,  8'd23,  8'd22,  8'd22,  8'd21,
    8'd21,  8'd21,  8'd20,  8'd20,  8'd20,  8'd20,  8'd20,  8'd20
  };

endpackage

// ----- rtl/mts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface mts_item_if;
  logic              valid;
  logic              ready;
  mts_pkg::item_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mts_result_if;
  logic              valid;
  logic              ready;
  mts_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mts_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mts_pkg::CFG_IDX_W-1:0]       index;
  logic [mts_pkg::CFG_DATA_W-1:0]      wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/morse_text_sender.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_text_sender
// Text-mode CW keyer advanced one millisecond per tick item.
// ----------------------------------------------------------------------------
// Each item (tick, enqueue, repeat load, clear, stop) gives one result in
// the output register on the next cycle; items may follow back to back
// unless the result output stalls. The text queue and repeat store are RAMs
// whose read ports prefetch the next head entry each cycle, with a write
// bypass, so a character popped on one tick is ready for the next item.
// Queue holds QUEUE_DEPTH-1 characters, the repeat message REPEAT_DEPTH-1.
// No clearing pass after reset. Register writes are always accepted.
module morse_text_sender (
  input  logic                 clk,
  input  logic                 rst,
  mts_item_if.sink             item_in,
  mts_result_if.source         result_out,
  mts_cfg_if.sink              cfg
);

  localparam int QW = mts_pkg::QPTR_W;
  localparam int RW = mts_pkg::RPTR_W;
  localparam logic [RW-1:0] RPT_MAX = RW'(mts_pkg::REPEAT_DEPTH - 1);

  logic [7:0]  text_queue [mts_pkg::QUEUE_DEPTH];
  logic [7:0]  repeat_store [mts_pkg::REPEAT_DEPTH];

  logic [QW-1:0] wptr, wptr_next, rptr, rptr_next;
  logic [RW-1:0] rlen, rlen_next, cidx, cidx_next;
  logic          copy_active, copy_active_next;
  logic [15:0]   idle_count, idle_count_next;
  logic          idle_armed, idle_armed_next;
  logic [6:0]    pattern, pattern_next;
  logic [2:0]    code_len, code_len_next;
  logic [2:0]    eidx, eidx_next;
  mts_pkg::phase_t phase, phase_next;
  logic [10:0]   remaining, remaining_next;
  logic [7:0]    dit_ms;
  logic [15:0]   gap_ms;

  // prefetch registers
  logic [7:0]  q_rdata, q_byp_data, r_rdata, r_byp_data;
  logic        q_byp, r_byp;
  logic [7:0]  q_head, r_head;

  logic          q_we, r_we;
  logic [QW-1:0] q_waddr;
  logic [RW-1:0] r_waddr;
  logic [7:0]    q_wdata, r_wdata;

  logic          accept;
  mts_pkg::item_t  it;
  mts_pkg::result_t res, res_reg;
  logic          out_valid;

  assign accept           = item_in.valid && item_in.ready;
  assign item_in.ready    = !out_valid || result_out.ready;
  assign it               = item_in.data;
  assign result_out.valid = out_valid;
  assign result_out.data  = res_reg;
  assign cfg.ready        = 1'b1;

  assign q_head = q_byp ? q_byp_data : q_rdata;
  assign r_head = r_byp ? r_byp_data : r_rdata;

  // scratch for the tick path
  logic [QW-1:0] wptr_a;
  logic [RW-1:0] cidx_a;
  logic          copy_a;
  logic [7:0]    ch, uc;
  logic [9:0]    cw;
  logic [7:0]    pat_ext;
  logic [10:0]   rem_c;
  logic [2:0]    eidx_inc;
  logic [RW-1:0] len_base;
  logic          key, busy, drop, abort;
  logic [15:0]   cnt_t;

  always_comb begin
    wptr_next        = wptr;
    rptr_next        = rptr;
    rlen_next        = rlen;
    cidx_next        = cidx;
    copy_active_next = copy_active;
    idle_count_next  = idle_count;
    idle_armed_next  = idle_armed;
    pattern_next     = pattern;
    code_len_next    = code_len;
    eidx_next        = eidx;
    phase_next       = phase;
    remaining_next   = remaining;
    q_we = 1'b0; q_waddr = wptr; q_wdata = it.char_code;
    r_we = 1'b0; r_waddr = rlen; r_wdata = it.char_code;
    wptr_a = wptr; cidx_a = cidx; copy_a = copy_active;
    ch = 8'd0; uc = 8'd0; cw = 10'd0; pat_ext = 8'd0; rem_c = 11'd0;
    eidx_inc = 3'd0; len_base = rlen; cnt_t = idle_count;
    key   = (phase == mts_pkg::PH_MARK);
    busy  = (phase != mts_pkg::PH_IDLE);
    drop  = 1'b0;
    abort = 1'b0;
    if (accept) begin
      case (it.func)
        mts_pkg::FUNC_ENQUEUE: begin
          if (it.char_code != 8'd0) begin
            if (QW'(wptr + 1'b1) == rptr) begin
              drop = 1'b1;
            end else begin
              q_we = 1'b1;
              wptr_next = QW'(wptr + 1'b1);
            end
          end
        end
        mts_pkg::FUNC_REPEAT: begin
          if (it.repeat_first) begin
            len_base = '0;
            rlen_next = '0;
            copy_active_next = 1'b0;
            idle_armed_next = 1'b1;
            idle_count_next = 16'hFFFF;
          end
          if (it.char_code != 8'd0) begin
            if (len_base < RPT_MAX) begin
              r_we = 1'b1;
              r_waddr = len_base;
              rlen_next = RW'(len_base + 1'b1);
            end else begin
              drop = 1'b1;
            end
          end
        end
        mts_pkg::FUNC_CLEAR: begin
          rlen_next = '0;
          copy_active_next = 1'b0;
        end
        mts_pkg::FUNC_STOP: begin
          wptr_next = '0;
          rptr_next = '0;
          rlen_next = '0;
          copy_active_next = 1'b0;
        end
        mts_pkg::FUNC_TICK: begin
          if (it.paddle && (phase != mts_pkg::PH_IDLE || wptr != rptr)) begin
            phase_next = mts_pkg::PH_IDLE;
            remaining_next = '0;
            wptr_next = '0;
            rptr_next = '0;
            rlen_next = '0;
            copy_active_next = 1'b0;
            idle_armed_next = 1'b0;
            idle_count_next = '0;
            abort = 1'b1;
            key = 1'b0;
            busy = 1'b0;
          end else begin
            // copy one repeat character into the queue
            if (copy_active) begin
              if (cidx < rlen) begin
                if (QW'(wptr + 1'b1) == rptr) begin
                  drop = 1'b1;
                  copy_a = 1'b0;
                end else begin
                  q_we = 1'b1;
                  q_wdata = r_head;
                  wptr_a = QW'(wptr + 1'b1);
                  cidx_a = RW'(cidx + 1'b1);
                end
              end
              if (cidx_a >= rlen) copy_a = 1'b0;
            end
            // take the next character
            if (phase == mts_pkg::PH_IDLE && wptr_a != rptr) begin
              ch = (wptr == rptr) ? r_head : q_head;
              rptr_next = QW'(rptr + 1'b1);
              uc = (ch >= 8'h61 && ch <= 8'h7A) ? 8'(ch - 8'h20) : ch;
              if (uc == 8'h20) begin
                phase_next = mts_pkg::PH_WORD_GAP;
                remaining_next = 11'(11'(dit_ms) * 11'd6);
              end else if (uc >= 8'h20 && uc <= 8'h5F) begin
                cw = mts_pkg::CW_TABLE[6'(uc - 8'h20)];
                if (cw[9:7] != 3'd0) begin
                  code_len_next = cw[9:7];
                  pattern_next = cw[6:0];
                  eidx_next = 3'd0;
                  phase_next = mts_pkg::PH_MARK;
                  remaining_next = cw[0] ? 11'(11'(dit_ms) * 11'd3) : 11'(dit_ms);
                end
              end
            end
            key  = (phase_next == mts_pkg::PH_MARK);
            busy = (phase_next != mts_pkg::PH_IDLE);
            // count down and advance
            if (phase_next != mts_pkg::PH_IDLE) begin
              rem_c = (remaining_next != 11'd0) ? 11'(remaining_next - 1'b1) : 11'd0;
              remaining_next = rem_c;
              if (rem_c == 11'd0) begin
                pat_ext = {1'b0, pattern_next};
                eidx_inc = 3'(eidx_next + 1'b1);
                case (phase_next)
                  mts_pkg::PH_MARK: begin
                    phase_next = mts_pkg::PH_ELEM_GAP;
                    remaining_next = 11'(dit_ms);
                  end
                  mts_pkg::PH_ELEM_GAP: begin
                    eidx_next = eidx_inc;
                    if (eidx_inc < code_len_next) begin
                      phase_next = mts_pkg::PH_MARK;
                      remaining_next = pat_ext[eidx_inc] ?
                                       11'(11'(dit_ms) * 11'd3) : 11'(dit_ms);
                    end else begin
                      phase_next = mts_pkg::PH_LETTER_GAP;
                      remaining_next = 11'({dit_ms, 1'b0});
                    end
                  end
                  default: begin
                    phase_next = mts_pkg::PH_IDLE;
                    remaining_next = '0;
                  end
                endcase
              end
            end
            wptr_next = wptr_a;
            cidx_next = cidx_a;
            copy_active_next = copy_a;
            // idle timer and start of a repeat copy
            if (phase_next == mts_pkg::PH_IDLE && wptr_a == rptr_next && !copy_a) begin
              cnt_t = idle_armed ? idle_count : 16'd0;
              idle_armed_next = 1'b1;
              idle_count_next = cnt_t;
              if (rlen != '0 && !it.paddle && cnt_t >= gap_ms) begin
                copy_active_next = 1'b1;
                cidx_next = '0;
                idle_armed_next = 1'b0;
              end else if (cnt_t != 16'hFFFF) begin
                idle_count_next = 16'(cnt_t + 1'b1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.key_down    = key;
    res.sending     = busy;
    res.repeating   = (rlen_next != '0);
    res.dropped     = drop;
    res.aborted     = abort;
    res.queue_empty = (wptr_next == rptr_next);
  end

  // memories with prefetch of the next head entry
  always_ff @(posedge clk) begin
    if (q_we) text_queue[q_waddr] <= q_wdata;
    q_rdata    <= text_queue[rptr_next];
    q_byp_data <= q_wdata;
    if (r_we) repeat_store[r_waddr] <= r_wdata;
    r_rdata    <= repeat_store[cidx_next];
    r_byp_data <= r_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; rlen <= '0; cidx <= '0;
      copy_active <= 1'b0; idle_count <= '0; idle_armed <= 1'b0;
      pattern <= '0; code_len <= '0; eidx <= '0;
      phase <= mts_pkg::PH_IDLE; remaining <= '0;
      dit_ms <= 8'd60; gap_ms <= '0;
      q_byp <= 1'b0; r_byp <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wptr <= wptr_next; rptr <= rptr_next; rlen <= rlen_next; cidx <= cidx_next;
      copy_active <= copy_active_next;
      idle_count <= idle_count_next; idle_armed <= idle_armed_next;
      pattern <= pattern_next; code_len <= code_len_next; eidx <= eidx_next;
      phase <= phase_next; remaining <= remaining_next;
      q_byp <= q_we && (q_waddr == rptr_next);
      r_byp <= r_we && (r_waddr == cidx_next);
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mts_pkg::CFG_WPM: dit_ms <= mts_pkg::DIT_TABLE[cfg.wdata[5:0]];
          mts_pkg::CFG_GAP: gap_ms <= cfg.wdata;
          default: begin
          end
        endcase
      end
      if (accept) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_reg <= res;
  end

  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_reg.aborted |->
      !res_reg.key_down && res_reg.queue_empty && !res_reg.repeating)
    else $error("abort left key or queue state behind");

  a_key_sending: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_reg.key_down |-> res_reg.sending)
    else $error("key down without a character in progress");

  a_stop_empties: assert property (@(posedge clk) disable iff (rst)
    accept && it.func == mts_pkg::FUNC_STOP |=> wptr == rptr && rlen == '0)
    else $error("stop did not clear queue and repeat message");

  a_idle_no_key: assert property (@(posedge clk) disable iff (rst)
    phase == mts_pkg::PH_IDLE |-> remaining == '0)
    else $error("idle phase with time left");

endmodule
